// File: rtl/fedl_pkg.sv
// Shared constants, types and register codes of the feedback echo delay line.
package fedl_pkg;

  // Delay store geometry
  localparam int unsigned Depth  = 4096;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned CntW   = AddrW + 1;

  // Payload widths
  localparam int unsigned SampleW   = 12;
  localparam int unsigned EntryW    = 13;
  localparam int unsigned OutW      = 14;
  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 16;

  // Configuration registers
  localparam int unsigned DelayW   = 9;
  localparam int unsigned StrW     = 7;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 9;

  // Loop length is the delay setting in tens of samples
  localparam int unsigned DelayScale = 10;
  localparam int unsigned LenRawW    = DelayW + 4;

  // Feedback factor is the tens digit of the strength, applied in percent
  localparam int unsigned StrStep = 10;
  localparam int unsigned KMax    = ((1 << StrW) - 1) / StrStep;
  localparam int unsigned KW      = $clog2(KMax + 1);
  localparam int unsigned PctDiv  = 100;

  // Divide by 100 through a reciprocal; exact for products below 2^24/84
  localparam int unsigned RecipShift = 24;
  localparam int unsigned RecipMul   = ((1 << RecipShift) + PctDiv - 1) / PctDiv;
  localparam int unsigned CoefW      = 21;
  localparam int unsigned ProdW      = EntryW + CoefW;
  localparam int unsigned FbW        = 10;

  // Output queue
  localparam int unsigned QDepth = 2;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    RegDelay    = 1'b0,
    RegFeedback = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CntW-1:0]  loop_len;
    logic [CoefW-1:0] coef;
  } fedl_cfg_t;

  typedef struct packed {
    logic              re;
    logic [AddrW-1:0]  raddr;
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [EntryW-1:0] wdata;
  } mem_req_t;

endpackage

// File: rtl/feedback_echo_delay_line.sv
// Top level of the feedback echo delay line: stream ports, item pipeline and store access.
//
// Feedback echo (comb filter) on unsigned 12-bit samples. For each word the
// entry under the write index is replaced with sample + (tens digit of the
// feedback strength) * entry / 100, the index advances and wraps at a loop
// length of ten times the delay setting (clamped to 4096, wrap to 0 right away
// when the setting is 0), and the output word is the sample plus the entry now
// under the index, an unsaturated 14-bit sum. A new word is taken only after
// the last one has left stage 1, and only with room left in the output
// queue: the delay store has a single read port and each word reads it
// twice, once for the entry it overwrites and once for the oldest entry.
// The store reads as zero after reset through a fill mark, so there is no
// clearing pass and words are accepted from the first cycle after reset.
// Configuration writes (index 0: delay setting, index 1: feedback strength)
// are always taken and must only be issued while no word is in flight; the
// strength is turned into a fixed-point coefficient when written.
module feedback_echo_delay_line (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fedl_pkg::InTdataW-1:0]     s_axis_tdata,   // [11:0] sample_in
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fedl_pkg::OutTdataW-1:0]    m_axis_tdata,   // [13:0] sample_out
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fedl_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [fedl_pkg::CfgDataW-1:0]     cfg_data_i
);
  import fedl_pkg::*;

  fedl_cfg_t         cfg;
  mem_req_t          mem_req;
  logic [EntryW-1:0] rdata;
  logic [QCntW-1:0]  q_cnt;

  // Write index and its successor
  logic [AddrW-1:0]  idx_d, idx_q;
  logic [CntW-1:0]   idx_inc;
  logic [AddrW-1:0]  nxt;
  logic              accept;

  // Stage 1: entry read is in flight, successor read goes out
  logic              s1_v_d, s1_v_q;
  logic [SampleW-1:0] s1_sample_q;
  logic [AddrW-1:0]  s1_idx_q;
  logic [AddrW-1:0]  s1_nxt_q;

  // Stage 2: write back the new entry, form the output sum
  logic              s2_v_d, s2_v_q;
  logic [SampleW-1:0] s2_sample_q;
  logic [AddrW-1:0]  s2_idx_q;
  logic              s2_same_q;
  logic [FbW-1:0]    s2_fb_q;

  logic [ProdW-1:0]  prod;
  logic [EntryW-1:0] entry;
  logic [EntryW-1:0] delayed;
  logic [OutW-1:0]   out_sum;
  logic [QCntW-1:0]  pending;

  fedl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Advance the index; wrap once it reaches the loop length
  assign idx_inc = CntW'(idx_q) + CntW'(1);
  assign nxt     = (idx_inc >= cfg.loop_len) ? '0 : idx_inc[AddrW-1:0];

  // Take a word only with stage 1 free and room for its result downstream:
  // stage 2 plus the queued results must leave one queue slot.
  assign pending       = QCntW'(s2_v_q) + q_cnt;
  assign s_axis_tready = !s1_v_q && (pending < QCntW'(QDepth));
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign idx_d  = accept ? nxt : idx_q;
  assign s1_v_d = accept;
  assign s2_v_d = s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  // Feedback term: entry * coef >> 24 is floor(tens digit * entry / 100)
  assign prod = ProdW'(rdata) * ProdW'(cfg.coef);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= s_axis_tdata[SampleW-1:0];
      s1_idx_q    <= idx_q;
      s1_nxt_q    <= nxt;
    end
    if (s1_v_q) begin
      s2_sample_q <= s1_sample_q;
      s2_idx_q    <= s1_idx_q;
      s2_same_q   <= s1_nxt_q == s1_idx_q;
      s2_fb_q     <= prod[RecipShift +: FbW];
    end
  end

  // New entry; when the index did not move, the oldest entry is the one just written
  assign entry   = EntryW'(s2_sample_q) + EntryW'(s2_fb_q);
  assign delayed = s2_same_q ? entry : rdata;
  assign out_sum = OutW'(s2_sample_q) + OutW'(delayed);

  // Read the overwritten entry on accept, the successor entry in stage 1.
  // The store forwards a write to a read of the same entry in the same cycle.
  always_comb begin
    mem_req.re    = accept || s1_v_q;
    mem_req.raddr = s1_v_q ? s1_nxt_q : idx_q;
    mem_req.we    = s2_v_q;
    mem_req.waddr = s2_idx_q;
    mem_req.wdata = entry;
  end

  fedl_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  fedl_outq u_outq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (s2_v_q),
    .push_data_i   (out_sum),
    .count_o       (q_cnt),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_stage1_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> !s_axis_tready)
    else $error("word accepted while stage 1 busy");

  a_one_read_per_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> !s2_v_q)
    else $error("stage 1 and stage 2 busy together");

  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (3'(s1_v_q) + 3'(s2_v_q) + 3'(q_cnt)) <= 3'(QDepth))
    else $error("more words in flight than queue slots");

endmodule

// File: rtl/fedl_cfg.sv
// Configuration registers: clamped loop length and premultiplied feedback coefficient.
module fedl_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fedl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fedl_pkg::CfgDataW-1:0]  cfg_data_i,
  output fedl_pkg::fedl_cfg_t            cfg_o
);
  import fedl_pkg::*;

  logic [CntW-1:0]    len_d, len_q;
  logic [CoefW-1:0]   coef_d, coef_q;
  logic [DelayW-1:0]  dly;
  logic [StrW-1:0]    str;
  logic [LenRawW-1:0] len_raw;
  logic [KW-1:0]      k;

  assign dly     = cfg_data_i[DelayW-1:0];
  assign str     = cfg_data_i[StrW-1:0];
  assign len_raw = LenRawW'(dly) * LenRawW'(DelayScale);

  // Tens digit of the strength
  always_comb begin
    k = '0;
    for (int unsigned j = 1; j <= KMax; j++) begin
      if (str >= StrW'(j * StrStep)) begin
        k = KW'(j);
      end
    end
  end

  always_comb begin
    len_d  = len_q;
    coef_d = coef_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegDelay: begin
          len_d = (len_raw > LenRawW'(Depth)) ? CntW'(Depth) : CntW'(len_raw);
        end
        RegFeedback: begin
          coef_d = CoefW'(k * RecipMul);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      coef_q <= '0;
    end else begin
      len_q  <= len_d;
      coef_q <= coef_d;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign cfg_o.loop_len = len_q;
  assign cfg_o.coef     = coef_q;

endmodule

// File: rtl/fedl_store.sv
// Delay store: one read and one write port, write-first, fill count for the zero reset.
module fedl_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fedl_pkg::mem_req_t            req_i,
  output logic [fedl_pkg::EntryW-1:0]   rdata_o
);
  import fedl_pkg::*;

  logic [EntryW-1:0] mem_q [Depth];
  logic [EntryW-1:0] rdata_q;
  logic              blank_q;
  logic [CntW-1:0]   fill_d, fill_q;
  logic              bypass;
  logic              known;

  // Writes only ever land at or below the fill mark, so entries below it are written
  assign bypass = req_i.we && (req_i.waddr == req_i.raddr);
  assign known  = CntW'(req_i.raddr) < fill_q;
  assign fill_d = (req_i.we && (CntW'(req_i.waddr) == fill_q)) ? fill_q + CntW'(1) : fill_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= bypass ? req_i.wdata : mem_q[req_i.raddr];
      blank_q <= !bypass && !known;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign rdata_o = blank_q ? '0 : rdata_q;

  a_write_within_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.we |-> (CntW'(req_i.waddr) <= fill_q))
    else $error("delay store written beyond fill mark");

endmodule

// File: rtl/fedl_outq.sv
// Two-entry output queue that drives the master stream.
module fedl_outq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [fedl_pkg::OutW-1:0]        push_data_i,
  output logic [fedl_pkg::QCntW-1:0]       count_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [fedl_pkg::OutTdataW-1:0]   m_axis_tdata  // [13:0] sample_out
);
  import fedl_pkg::*;

  logic [OutW-1:0]  slot_q [QDepth];
  logic             wr_ptr_d, wr_ptr_q;
  logic             rd_ptr_d, rd_ptr_q;
  logic [QCntW-1:0] cnt_d, cnt_q;
  logic             pop;

  assign pop      = m_axis_tvalid && m_axis_tready;
  assign wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
  assign rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign count_o       = cnt_q;
  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tdata  = {{(OutTdataW - OutW){1'b0}}, slot_q[rd_ptr_q]};

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != QCntW'(QDepth)))
    else $error("output queue overflow");

endmodule

// File: sim/tb_feedback_echo_delay_line.sv
// Self-checking testbench of the feedback echo delay line.
module tb_feedback_echo_delay_line;
  import fedl_pkg::*;

  // Cycles from input acceptance to output valid, and the watchdog limit.
  // The limit covers every word waiting out the longest sender gap, the
  // slowest receiver pattern and the pace of the block itself,
  // with plenty of margin.
  localparam int unsigned LatencyCycles = 3;
  localparam int unsigned CycleLimit    = 500000;
  localparam int unsigned RandPhases    = 10;
  localparam int unsigned WordsPerPhase = 185;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Drive every input to a known value from time zero.
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InTdataW-1:0]    s_axis_tdata  = '0;   // [11:0] sample_in
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutTdataW-1:0]   m_axis_tdata;         // [13:0] sample_out
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxW-1:0]     cfg_index_i   = RegDelay;
  logic [CfgDataW-1:0]    cfg_data_i    = '0;

  feedback_echo_delay_line dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Echo predictor: its own copy of the delay store, the write index and the
  // two settings. The store starts all zero, as the block's does after reset.
  // ---------------------------------------------------------------------------
  logic [EntryW-1:0] echo_mem [Depth];
  logic [AddrW-1:0]  echo_wr_idx   = '0;
  logic [DelayW-1:0] echo_delay    = '0;
  logic [StrW-1:0]   echo_strength = '0;

  logic [SampleW-1:0] samples_pending [$];   // words waiting for the driver
  logic [OutW-1:0]    echo_sums_due   [$];   // predicted output words, oldest first

  int unsigned fail_count    = 0;
  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned settings_run  = 0;
  int unsigned cycle_count   = 0;

  initial begin
    for (int i = 0; i < Depth; i++) echo_mem[i] = '0;
  end

  // Overwrite the entry under the index with the sample plus the scaled old
  // entry, advance and wrap the index, then return the sample plus the entry
  // now under the index (the oldest one in the loop).
  function automatic logic [OutW-1:0] echo_sum(logic [SampleW-1:0] smp);
    int unsigned loop_len;
    int unsigned idx;
    int unsigned old_entry;
    int unsigned entry;
    loop_len = int'(echo_delay) * 10;
    if (loop_len > Depth) loop_len = Depth;
    idx       = echo_wr_idx;
    old_entry = echo_mem[idx];
    entry     = smp + ((int'(echo_strength) / 10) * old_entry) / 100;
    echo_mem[idx] = entry[EntryW-1:0];
    idx = idx + 1;
    // Zero delay and a delay shortened below the index both wrap to 0 here.
    if (idx >= loop_len) idx = 0;
    echo_wr_idx = idx[AddrW-1:0];
    return OutW'(smp) + OutW'(echo_mem[idx]);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present words from the pending queue in bursts of random length
  // with random gaps; hold a word until it is taken.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        echo_sums_due.push_back(echo_sum(s_axis_tdata[SampleW-1:0]));
        words_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (samples_pending.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(InTdataW-SampleW){1'b0}}, samples_pending.pop_front()};
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            // A quarter of the bursts run straight into the next one.
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switch between stall patterns after spans of random length --
  // always ready, coin flip, one cycle in four, and mostly stalled.
  // ---------------------------------------------------------------------------
  int unsigned ready_mode = 0;
  int unsigned ready_span = 0;

  always @(posedge clk_i) begin
    logic ready_next;
    if (ready_span == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_span = $urandom_range(50, 300);
    end else begin
      ready_span--;
    end
    case (ready_mode)
      0: begin
        ready_next = 1'b1;
      end
      1: begin
        ready_next = 1'($urandom_range(0, 1));
      end
      2: begin
        ready_next = (cycle_count % 4) == 0;
      end
      default: begin
        ready_next = ($urandom_range(0, 7) == 0);
      end
    endcase
    m_axis_tready <= ready_next;
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each output word with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic [OutW-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (echo_sums_due.size() == 0) begin
        $error("sample_out: no word expected, actual %0d", m_axis_tdata[OutW-1:0]);
        fail_count++;
      end else begin
        want = echo_sums_due.pop_front();
        if (m_axis_tdata[OutW-1:0] !== want) begin
          $error("sample_out: expected %0d, actual %0d", want, m_axis_tdata[OutW-1:0]);
          fail_count++;
        end
        words_checked++;
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Write one register while the block is idle, and mirror it in the predictor.
  task automatic cfg_write(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegDelay) begin
      echo_delay = val[DelayW-1:0];
    end else begin
      echo_strength = val[StrW-1:0];
    end
  endtask

  // Wait until every queued word has gone in and every prediction has come
  // back, then let the pipeline drain a little more.
  task automatic settle();
    while (samples_pending.size() != 0 || s_axis_tvalid || echo_sums_due.size() != 0)
      @(posedge clk_i);
    repeat (2 * LatencyCycles) @(posedge clk_i);
    settings_run++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [DelayW-1:0] delay_plan [RandPhases] = '{0, 3, 511, 1, 12, 410, 7, 409, 2, 0};
  logic [StrW-1:0]   str_plan   [RandPhases] = '{127, 50, 100, 0, 99, 10, 0, 9, 127, 0};

  initial begin
    int unsigned pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero delay with the largest factor: each word lands on entry 0 and the
    // output reads back the entry just written.
    cfg_write(RegDelay, 9'd0);
    cfg_write(RegFeedback, 9'd127);
    samples_pending = '{12'hFFF, 12'hFFF, 12'h000, 12'hAAA, 12'h555, 12'h001};
    settle();

    // Twenty-sample loop at strength 100: full-scale words with a few others.
    cfg_write(RegDelay, 9'd2);
    cfg_write(RegFeedback, 9'd100);
    repeat (12) samples_pending.push_back(12'hFFF);
    samples_pending.push_back(12'h000);
    samples_pending.push_back(12'hFFF);
    samples_pending.push_back(12'h800);
    settle();

    // Shorten the loop below the current index and drop the factor to zero.
    cfg_write(RegDelay, 9'd1);
    cfg_write(RegFeedback, 9'd9);
    samples_pending = '{12'hFFF, 12'h000, 12'h001};
    settle();

    // Random phases: mostly short loops where feedback builds up, plus loops
    // at and past the store size; strength writes carry random upper bits.
    delay_plan[RandPhases-1] = DelayW'($urandom_range(0, 511));
    str_plan[6]              = StrW'($urandom_range(0, 127));
    str_plan[RandPhases-1]   = StrW'($urandom_range(0, 127));
    for (int p = 0; p < RandPhases; p++) begin
      cfg_write(RegDelay, delay_plan[p]);
      cfg_write(RegFeedback, {2'($urandom), str_plan[p]});
      for (int k = 0; k < WordsPerPhase; k++) begin
        pick = $urandom_range(0, 7);
        samples_pending.push_back(pick == 0 ? 12'hFFF : pick == 1 ? 12'h000 : 12'($urandom));
      end
      settle();
    end

    $display("Run covered %0d sample words and %0d checked outputs over %0d settings,",
             words_sent, words_checked, settings_run);
    $display("with delays from zero to past the store size and a spread of feedback factors.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/fedl_pkg.sv
rtl/fedl_cfg.sv
rtl/fedl_store.sv
rtl/fedl_outq.sv
rtl/feedback_echo_delay_line.sv
sim/tb_feedback_echo_delay_line.sv
